// ===== design/dcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants for the debounced click counter.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Field and register widths
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned ClicksW  = 8;
  localparam int unsigned DebW     = 8;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned StepW    = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [DebW-1:0]  DebounceReset = 8'd15;
  localparam logic [WaitW-1:0] WaitReset     = 16'd300;
  localparam logic [StepW-1:0] StepReset     = 8'd5;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgAddrW-1:0] RegWait     = 2'd1;
  localparam logic [CfgAddrW-1:0] RegStep     = 2'd2;

  // Button mode machine
  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_HIGH     = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_DEBOUNCE = 3'd3,
    MODE_WAIT     = 3'd4
  } mode_t;

endpackage : dcc_pkg
`default_nettype wire

// ===== design/debounced_click_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_click_counter
// Button debouncer and multi-click burst detector, one pin sample per item.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item carries one sampled pin level (in_tdata bit 0), normally
//   one per timer tick. Every accepted item yields exactly one result item:
//   out_tuser[0] is set when a click burst ended on that tick, and out_tdata
//   then holds the number of clicks in the burst (zero otherwise).
//   The configuration port writes debounce time (index 0), wait time
//   (index 1) and tick step (index 2); other indexes are ignored. Write only
//   while no item is in flight.
// Pipeline and throughput:
//   An item is registered at acceptance; its result is registered once the
//   result register is free, which a stalled receiver can delay. One item
//   per cycle is sustained while out_tready is high. Mode, elapsed time and
//   click count change in the single compute stage between the registers.
// Reset and stall:
//   rst_n (synchronous, active low) empties both stages, puts the machine in
//   its initial mode and restores the register defaults. When the receiver
//   holds out_tready low, the result register holds its item, the input
//   stage takes one more item only if it was empty, then in_tready drops.
// ----------------------------------------------------------------------------
module debounced_click_counter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel; in_tdata: [0] pin_level, [7:1] zero
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [7:0]                       in_tdata,
  // Result channel; out_tdata: [7:0] click_count; out_tuser: [0] report_valid
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [7:0]                       out_tdata,
  output      logic [0:0]                       out_tuser,
  // Configuration port
  input  wire logic                             cfg_wen,
  input  wire logic [dcc_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [dcc_pkg::CfgDataW-1:0]     cfg_wdata
);
  import dcc_pkg::*;

  // Configuration registers
  logic [DebW-1:0]     debounce_time_r;
  logic [WaitW-1:0]    wait_time_r;
  logic [StepW-1:0]    tick_step_r;

  // Input stage
  logic                s1_valid_r;
  logic                pin_r;

  // Machine state
  mode_t               mode_r, mode_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;
  logic [ClicksW-1:0]  clicks_r, clicks_nxt;
  logic                in_burst_r, in_burst_nxt;

  // Result register
  logic                out_valid_r;
  logic                report_r, report_nxt;
  logic [ClicksW-1:0]  count_r, count_nxt;

  logic                s1_advance;
  logic [ElapsedW:0]   elapsed_sum;
  logic [ElapsedW-1:0] elapsed_sat;
  logic [ClicksW-1:0]  clicks_base;

  // Handshake: the compute stage moves when the result register is free
  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= DebounceReset;
      wait_time_r     <= WaitReset;
      tick_step_r     <= StepReset;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        RegDebounce: debounce_time_r <= cfg_wdata[DebW-1:0];
        RegWait:     wait_time_r     <= cfg_wdata[WaitW-1:0];
        RegStep:     tick_step_r     <= cfg_wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pin_r <= in_tdata[0];
    end
  end

  // Saturating advance of the elapsed time
  assign elapsed_sum = {1'b0, elapsed_r} + {{(ElapsedW + 1 - StepW){1'b0}}, tick_step_r};
  assign elapsed_sat = elapsed_sum[ElapsedW] ? {ElapsedW{1'b1}} : elapsed_sum[ElapsedW-1:0];
  // A new burst restarts the click count
  assign clicks_base = in_burst_r ? clicks_r : '0;

  // Next state and result for the item in the input stage
  always_comb begin
    mode_nxt     = mode_r;
    elapsed_nxt  = elapsed_sat;
    clicks_nxt   = clicks_r;
    in_burst_nxt = in_burst_r;
    report_nxt   = 1'b0;
    count_nxt    = '0;
    unique case (mode_r)
      MODE_INIT: begin
        mode_nxt = pin_r ? MODE_HIGH : MODE_LOW;
      end
      MODE_HIGH: begin
        if (!pin_r) begin
          mode_nxt    = MODE_DEBOUNCE;
          elapsed_nxt = '0;
        end
      end
      MODE_LOW: begin
        if (pin_r) begin
          mode_nxt    = MODE_DEBOUNCE;
          elapsed_nxt = '0;
        end
      end
      MODE_DEBOUNCE: begin
        if (elapsed_sat >= {{(ElapsedW - DebW){1'b0}}, debounce_time_r}) begin
          if (!pin_r) begin
            in_burst_nxt = 1'b1;
            clicks_nxt   = clicks_base + 1'b1;
            elapsed_nxt  = '0;
            mode_nxt     = MODE_WAIT;
          end else begin
            mode_nxt = MODE_HIGH;
          end
        end
      end
      MODE_WAIT: begin
        if (elapsed_sat < wait_time_r) begin
          if (pin_r) begin
            elapsed_nxt = '0;
            mode_nxt    = MODE_DEBOUNCE;
          end
        end else begin
          report_nxt   = 1'b1;
          count_nxt    = clicks_r;
          mode_nxt     = MODE_LOW;
          in_burst_nxt = 1'b0;
        end
      end
      default: begin
        mode_nxt = MODE_INIT;
      end
    endcase
  end

  // State update, one item per cycle while the result register is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_INIT;
      elapsed_r  <= '0;
      clicks_r   <= '0;
      in_burst_r <= 1'b0;
    end else if (s1_valid_r && s1_advance) begin
      mode_r     <= mode_nxt;
      elapsed_r  <= elapsed_nxt;
      clicks_r   <= clicks_nxt;
      in_burst_r <= in_burst_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance) begin
      report_r <= report_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = count_r;
  assign out_tuser[0] = report_r;

endmodule : debounced_click_counter
`default_nettype wire

// ===== test/dcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_checker
// Watches the pin, result and register ports of the debounced click counter.
// It keeps its own copy of the button machine and registers, works out the
// report for every accepted pin item, and compares each result item in order.
// ----------------------------------------------------------------------------
module dcc_checker
  import dcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [7:0]          out_tdata,
  input  logic [0:0]          out_tuser,
  input  logic                cfg_wen,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int unsigned         mismatch_count,
  output int unsigned         reports_pending
);

  typedef struct packed {
    logic               report_valid;
    logic [ClicksW-1:0] click_count;
  } report_t;

  // Register copies.
  logic [DebW-1:0]     deb_r;
  logic [WaitW-1:0]    wait_r;
  logic [StepW-1:0]    step_r;

  // Button machine copy.
  mode_t               mode_r;
  logic [ElapsedW-1:0] elapsed_r;
  logic [ClicksW-1:0]  clicks_r;
  logic                in_burst_r;

  // Reports still owed by the block, oldest first.
  report_t             report_q[$];

  initial begin
    mismatch_count  = 0;
    reports_pending = 0;
  end

  // Counts a failure and prints the first few of them.
  task automatic flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Advances the button machine by one tick and returns its report.
  task automatic advance_button(input logic pin_high, output report_t rep);
    logic [ElapsedW:0] sum;
    sum = {1'b0, elapsed_r} + {{(ElapsedW+1-StepW){1'b0}}, step_r};
    elapsed_r = sum[ElapsedW] ? {ElapsedW{1'b1}} : sum[ElapsedW-1:0];
    rep = '0;
    case (mode_r)
      MODE_INIT: begin
        mode_r = pin_high ? MODE_HIGH : MODE_LOW;
      end
      MODE_HIGH: begin
        if (!pin_high) begin
          mode_r    = MODE_DEBOUNCE;
          elapsed_r = '0;
        end
      end
      MODE_LOW: begin
        if (pin_high) begin
          mode_r    = MODE_DEBOUNCE;
          elapsed_r = '0;
        end
      end
      MODE_DEBOUNCE: begin
        if (elapsed_r >= ElapsedW'(deb_r)) begin
          if (!pin_high) begin
            // A confirmed press; the first one of a burst restarts the count.
            if (!in_burst_r) begin
              in_burst_r = 1'b1;
              clicks_r   = '0;
            end
            elapsed_r = '0;
            clicks_r  = clicks_r + 1'b1;
            mode_r    = MODE_WAIT;
          end else begin
            mode_r = MODE_HIGH;
          end
        end
      end
      MODE_WAIT: begin
        if (elapsed_r < wait_r) begin
          if (pin_high) begin
            elapsed_r = '0;
            mode_r    = MODE_DEBOUNCE;
          end
        end else begin
          // Wait window is over: the burst ends whatever the pin does.
          rep.report_valid = 1'b1;
          rep.click_count  = clicks_r;
          mode_r           = MODE_LOW;
          in_burst_r       = 1'b0;
        end
      end
      default: begin
        mode_r = MODE_INIT;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    report_t want;
    report_t seen;
    if (!rst_n) begin
      deb_r      = DebounceReset;
      wait_r     = WaitReset;
      step_r     = StepReset;
      mode_r     = MODE_INIT;
      elapsed_r  = '0;
      clicks_r   = '0;
      in_burst_r = 1'b0;
      report_q.delete();
    end else begin
      // Register writes; unknown indexes are dropped.
      if (cfg_wen) begin
        case (cfg_addr)
          RegDebounce: deb_r  = cfg_wdata[DebW-1:0];
          RegWait:     wait_r = cfg_wdata[WaitW-1:0];
          RegStep:     step_r = cfg_wdata[StepW-1:0];
          default:     ;
        endcase
      end

      // Result side: match against the oldest outstanding report.
      if (out_tvalid && out_tready) begin
        seen.report_valid = out_tuser[0];
        seen.click_count  = out_tdata;
        if (report_q.size() == 0) begin
          flag($sformatf("result item with none outstanding: report_valid %0b click_count %0d",
                         seen.report_valid, seen.click_count));
        end else begin
          want = report_q.pop_front();
          if (seen.report_valid !== want.report_valid) begin
            flag($sformatf("report_valid: expected %0b, got %0b",
                           want.report_valid, seen.report_valid));
          end
          if (seen.click_count !== want.click_count) begin
            flag($sformatf("click_count: expected %0d, got %0d",
                           want.click_count, seen.click_count));
          end
        end
      end

      // Pin side: every accepted item owes exactly one report.
      if (in_tvalid && in_tready) begin
        advance_button(in_tdata[0], want);
        report_q.push_back(want);
      end
    end
    reports_pending <= report_q.size();
  end

endmodule

// ===== test/tb_debounced_click_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_click_counter
// Drives pin samples and register settings into the click counter under
// bursty input and a stalling receiver; a checker beside it scores results.
// ----------------------------------------------------------------------------
module tb_debounced_click_counter;
  import dcc_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned NumRandPhases = 4;
  localparam int unsigned PhaseItems = 100;

  // Receiver stall patterns.
  localparam int ReadyFull   = 0;
  localparam int ReadyMost   = 1;
  localparam int ReadySparse = 2;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic [0:0]          out_tuser;
  logic                cfg_wen    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  int unsigned mismatch_count;
  int unsigned reports_pending;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          ready_mode = ReadyFull;
  int          ready_span = 0;

  debounced_click_counter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dcc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wen         (cfg_wen),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver switches between stall patterns, holding each for a random span.
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(ReadySparse, ReadyFull);
      ready_span <= $urandom_range(20, 80);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      ReadyFull: out_tready <= 1'b1;
      ReadyMost: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sends one pin item, opening a new burst after a random gap when due.
  task automatic push_sample(input logic pin_high);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, pin_high};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_run(input logic pin_high, input int n);
    repeat (n) push_sample(pin_high);
  endtask

  // Stops sending and waits until every report has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (reports_pending != 0);
  endtask

  task automatic set_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Loads all three registers once the block is idle; spare high bits are junk.
  task automatic configure(input int deb, input int wait_len, input int step);
    drain();
    set_reg(RegDebounce, {8'($urandom), 8'(deb)});
    set_reg(RegWait, 16'(wait_len));
    set_reg(RegStep, {8'($urandom), 8'(step)});
  endtask

  initial begin : stimulus
    int deb;
    int wait_len;
    int step;
    int deb_ticks;
    int wait_ticks;
    int n_clicks;
    int start_cnt;
    int sent;
    int len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: two debounced clicks, then a bounce in debounce.
    send_run(1'b1, 2);
    send_run(1'b0, 4);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    drain();
    set_reg(RegUnused, 16'hFFFF);
    set_reg(RegWait, 16'd20);
    send_run(1'b0, 5);
    send_run(1'b1, 4);

    // Zero step, zero debounce and zero wait: burst ends on first wait tick.
    configure(0, 0, 0);
    send_run(1'b0, 3);
    send_run(1'b1, 2);
    send_run(1'b0, 3);

    // Largest settings: elapsed climbs to saturation before the report.
    configure(255, 65535, 255);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b0, 262);

    // Random settings with mostly well-formed click bursts.
    sent = 0;
    for (int ph = 0; ph < NumRandPhases; ph++) begin
      step     = $urandom_range(1, 8);
      deb      = $urandom_range(0, 4 * step);
      wait_len = $urandom_range(0, 12 * step);
      configure(deb, wait_len, step);
      deb_ticks  = (deb + step - 1) / step;
      wait_ticks = (wait_len + step - 1) / step;
      if (deb_ticks < 1) deb_ticks = 1;
      if (wait_ticks < 1) wait_ticks = 1;
      start_cnt = sent;
      while (sent - start_cnt < PhaseItems) begin
        if ($urandom_range(0, 9) < 2) begin
          // Pin noise.
          len = $urandom_range(1, 6);
          repeat (len) push_sample(1'($urandom_range(0, 1)));
          sent += len;
        end else begin
          n_clicks = $urandom_range(1, 4);
          for (int c = 0; c < n_clicks; c++) begin
            len = deb_ticks + $urandom_range(0, 2);
            send_run(1'b1, len);
            sent += len;
            // Occasionally one tick short, which makes a bounce.
            len = deb_ticks + $urandom_range(0, 2) - 1;
            if (len < 1) len = 1;
            send_run(1'b0, len);
            sent += len;
            if (c + 1 < n_clicks) begin
              len = $urandom_range(0, (wait_ticks > 1) ? wait_ticks - 2 : 0);
              send_run(1'b0, len);
              sent += len;
            end
          end
          len = wait_ticks + $urandom_range(0, 2);
          send_run(1'b0, len);
          sent += len;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== debounced_click_counter.f =====
design/dcc_pkg.sv
design/debounced_click_counter.sv
test/dcc_checker.sv
test/tb_debounced_click_counter.sv
